[hw/rtl/acs_pkg.sv]
// Shared types, register indexes, status codes and reset values for the
// affine cipher symbol block. No dependencies.
`default_nettype none

package acs_pkg;

  localparam int SYMBOL_BITS_DEF = 8;

  localparam int KEY_W      = 8;
  localparam int ASZ_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int STATUS_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MULT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ADD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SIZE = 2'd2;

  // Register values after reset.
  localparam logic [KEY_W-1:0] KEY_MULT_RST   = 8'd1;
  localparam logic [KEY_W-1:0] KEY_ADD_RST    = 8'd0;
  localparam logic [ASZ_W-1:0] ALPHA_SIZE_RST = 9'd26;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOINV = 2'd2;

  // Opcode of an encrypt request.
  localparam logic OP_ENC = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0] key_mult;
    logic [KEY_W-1:0] key_add;
    logic [ASZ_W-1:0] alpha_size;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/acs_div.sv]
// Shared restoring divider, one quotient bit per cycle, with a long and a
// short dividend mode. Depends on nothing but its parameters.
`default_nettype none

module acs_div #(
  parameter int DW = 16,
  parameter int MW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          long_mode,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [MW-1:0] divisor,
  output logic               done,
  output logic [MW-1:0]      quo,
  output logic [MW-1:0]      rem
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    dvd_r;
  logic [MW-1:0]    dvs_r;
  logic [MW-1:0]    rem_r;
  logic [MW-1:0]    quo_r;

  logic [MW:0]      trial;
  logic [MW:0]      diff;
  logic             ge;
  logic [MW-1:0]    rem_nxt;

  assign trial   = {rem_r, dvd_r[DW-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[MW-1:0] : trial[MW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= long_mode ? CNT_W'(DW) : CNT_W'(MW);
        // The short mode only walks the low MW bits of the dividend.
        dvd_r  <= long_mode ? dividend : {dividend[MW-1:0], {(DW-MW){1'b0}}};
        dvs_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
        rem_r <= rem_nxt;
        quo_r <= {quo_r[MW-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");

endmodule

`default_nettype wire

[hw/rtl/acs_ctrl.sv]
// Sequencer and datapath for one symbol request: key reduction, encrypt,
// extended Euclid inverse and decrypt. Uses acs_pkg and acs_div.
`default_nettype none

module acs_ctrl #(
  parameter int SYMBOL_BITS = acs_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire acs_pkg::cfg_t                 cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic [SYMBOL_BITS-1:0]        in_symbol,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic [SYMBOL_BITS-1:0]             res_sym,
  output logic [acs_pkg::STATUS_W-1:0]       res_status
);

  localparam int SB = SYMBOL_BITS;
  localparam int MW = SB + 1;
  localparam int SW = MW + 1;
  localparam int DW = (2 * SB > acs_pkg::KEY_W) ? 2 * SB : acs_pkg::KEY_W;
  localparam int XW = (MW > acs_pkg::ASZ_W) ? MW : acs_pkg::ASZ_W;
  localparam logic [XW-1:0] MAX_MOD = XW'(1) << SB;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KA   = 4'd1;
  localparam logic [3:0] S_KAW  = 4'd2;
  localparam logic [3:0] S_KBW  = 4'd3;
  localparam logic [3:0] S_ENC  = 4'd4;
  localparam logic [3:0] S_EU   = 4'd5;
  localparam logic [3:0] S_EUW  = 4'd6;
  localparam logic [3:0] S_INV  = 4'd7;
  localparam logic [3:0] S_DMUL = 4'd8;
  localparam logic [3:0] S_RESW = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]                    state_r;
  logic                          op_r;
  logic [SB-1:0]                 p_r;
  logic [MW-1:0]                 m_r;
  logic [MW-1:0]                 a_r;
  logic [MW-1:0]                 b_r;
  logic [MW-1:0]                 r0_r;
  logic [MW-1:0]                 r1_r;
  logic signed [SW-1:0]          s0_r;
  logic signed [SW-1:0]          s1_r;
  logic [SB-1:0]                 res_r;
  logic [acs_pkg::STATUS_W-1:0]  status_r;

  logic [XW-1:0]                 asz_x;
  logic [MW-1:0]                 m_new;
  logic signed [SW-1:0]          mul_x;
  logic signed [SW-1:0]          mul_y;
  logic signed [2*SW-1:0]        mul_p;
  logic signed [SW-1:0]          s1_nxt;
  logic signed [SW-1:0]          m_s;
  logic signed [SW-1:0]          inv_s;
  logic [MW:0]                   d_sum;
  logic [MW:0]                   d_red;

  logic                          div_start;
  logic                          div_long;
  logic [DW-1:0]                 div_dvd;
  logic [MW-1:0]                 div_dvs;
  logic                          div_done;
  logic [MW-1:0]                 div_quo;
  logic [MW-1:0]                 div_rem;

  // Effective modulus: alpha_size clamped into 2 .. 2^SB.
  assign asz_x = XW'(cfg.alpha_size);
  always_comb begin
    if (asz_x < XW'(2)) begin
      m_new = MW'(2);
    end else if (asz_x > MAX_MOD) begin
      m_new = MAX_MOD[MW-1:0];
    end else begin
      m_new = asz_x[MW-1:0];
    end
  end

  // One shared multiplier; all operands but s1 are non-negative.
  always_comb begin
    unique case (state_r)
      S_ENC: begin
        mul_x = {1'b0, a_r};
        mul_y = {2'b00, p_r};
      end
      S_DMUL: begin
        mul_x = {1'b0, a_r};
        mul_y = {1'b0, b_r};
      end
      default: begin
        mul_x = {1'b0, div_quo};
        mul_y = s1_r;
      end
    endcase
  end

  assign mul_p  = mul_x * mul_y;
  assign s1_nxt = s0_r - signed'(mul_p[SW-1:0]);

  // Bring the Bezout coefficient into 0 .. m-1 and form (p - b) mod m.
  assign m_s = signed'({1'b0, m_r});
  always_comb begin
    if (s0_r < 0) begin
      inv_s = s0_r + m_s;
    end else if (s0_r >= m_s) begin
      inv_s = s0_r - m_s;
    end else begin
      inv_s = s0_r;
    end
  end

  assign d_sum = {1'b0, m_r} + {2'b00, p_r} - {1'b0, b_r};
  assign d_red = (d_sum >= {1'b0, m_r}) ? d_sum - {1'b0, m_r} : d_sum;

  // Divider requests.
  always_comb begin
    div_start = 1'b0;
    div_long  = 1'b1;
    div_dvd   = '0;
    div_dvs   = m_r;
    unique case (state_r)
      S_KA: begin
        div_start = 1'b1;
        div_dvd   = DW'(cfg.key_mult);
      end
      S_KAW: begin
        div_start = div_done;
        div_dvd   = DW'(cfg.key_add);
      end
      S_ENC: begin
        div_start = 1'b1;
        div_dvd   = mul_p[DW-1:0] + DW'(b_r);
      end
      S_EU: begin
        div_start = (r1_r != '0);
        div_long  = 1'b0;
        div_dvd   = DW'(r0_r);
        div_dvs   = r1_r;
      end
      S_DMUL: begin
        div_start = 1'b1;
        div_dvd   = mul_p[DW-1:0];
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  acs_div #(
    .DW(DW),
    .MW(MW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .long_mode (div_long),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quo       (div_quo),
    .rem       (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_opcode;
            p_r  <= in_symbol;
            m_r  <= m_new;
            if ({1'b0, in_symbol} >= m_new) begin
              res_r    <= '0;
              status_r <= acs_pkg::ST_RANGE;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_KA;
            end
          end
        end
        S_KA: begin
          state_r <= S_KAW;
        end
        S_KAW: begin
          if (div_done) begin
            a_r     <= div_rem;
            state_r <= S_KBW;
          end
        end
        S_KBW: begin
          if (div_done) begin
            b_r <= div_rem;
            if (op_r == acs_pkg::OP_ENC) begin
              state_r <= S_ENC;
            end else begin
              r0_r    <= m_r;
              r1_r    <= a_r;
              s0_r    <= '0;
              s1_r    <= SW'(1);
              state_r <= S_EU;
            end
          end
        end
        S_ENC: begin
          state_r <= S_RESW;
        end
        S_EU: begin
          if (r1_r == '0) begin
            if (r0_r == MW'(1)) begin
              state_r <= S_INV;
            end else begin
              res_r    <= '0;
              status_r <= acs_pkg::ST_NOINV;
              state_r  <= S_DONE;
            end
          end else begin
            state_r <= S_EUW;
          end
        end
        S_EUW: begin
          if (div_done) begin
            r0_r    <= r1_r;
            r1_r    <= div_rem;
            s0_r    <= s1_r;
            s1_r    <= s1_nxt;
            state_r <= S_EU;
          end
        end
        S_INV: begin
          a_r     <= inv_s[MW-1:0];
          b_r     <= d_red[MW-1:0];
          state_r <= S_DMUL;
        end
        S_DMUL: begin
          state_r <= S_RESW;
        end
        S_RESW: begin
          if (div_done) begin
            res_r    <= div_rem[SB-1:0];
            status_r <= acs_pkg::ST_OK;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res_sym    = res_r;
  assign res_status = status_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while a symbol is in work");

  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_status == acs_pkg::ST_OK) |-> ({1'b0, res_sym} < m_r))
    else $error("result symbol not below the modulus");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_status != acs_pkg::ST_OK) |-> (res_sym == '0))
    else $error("error result carries a nonzero symbol");

endmodule

`default_nettype wire

[hw/rtl/affine_cipher_symbol.sv]
// Affine cipher on one alphabet index per request: top level with the
// key registers and the output register. Uses acs_pkg and acs_ctrl.
//
// Usage. A request on the in_ channel carries an opcode (encrypt or
// decrypt) and a symbol index; it is taken when in_valid and in_ready are
// both high. Every request gives exactly one result on the out_ channel,
// a symbol index and a status, taken when out_valid and out_ready are both
// high. Keys and the alphabet size are written through cfg_we, cfg_idx and
// cfg_wdata, one register per clock, while no request is in work.
//
// Timing. With DW = max(2*SYMBOL_BITS, 8) and MW = SYMBOL_BITS + 1, one
// shared restoring divider retiring one quotient bit per cycle sets the
// pace. A symbol out of range goes straight to its result. Encrypt reduces
// both keys mod m on the divider and then reduces a*p + b; decrypt reduces
// both keys, runs one short divide per Euclid step and then reduces the
// product of the inverse and (p - b) mod m. in_ready is low while a symbol
// is in work; one request at a time.
//
// Reset (rst_n low at a clock edge) sets key_mult to 1, key_add to 0 and
// the alphabet size to 26, and drops any request in work. While the
// receiver stalls, the result waits in the output register and the next
// request may already be taken and computed behind it.
`default_nettype none

module affine_cipher_symbol #(
  parameter int SYMBOL_BITS = acs_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_opcode,
  input  wire logic [SYMBOL_BITS-1:0]           in_symbol_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [SYMBOL_BITS-1:0]                out_symbol_out,
  output logic [acs_pkg::STATUS_W-1:0]          out_status,
  input  wire logic                             cfg_we,
  input  wire logic [acs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [acs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  acs_pkg::cfg_t                 cfg_r;

  logic                          res_valid;
  logic                          res_ready;
  logic [SYMBOL_BITS-1:0]        res_sym;
  logic [acs_pkg::STATUS_W-1:0]  res_status;

  logic                          out_valid_r;
  logic [SYMBOL_BITS-1:0]        out_sym_r;
  logic [acs_pkg::STATUS_W-1:0]  out_status_r;

  // Key registers. A write to an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_mult   <= acs_pkg::KEY_MULT_RST;
      cfg_r.key_add    <= acs_pkg::KEY_ADD_RST;
      cfg_r.alpha_size <= acs_pkg::ALPHA_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        acs_pkg::CFG_KEY_MULT: begin
          cfg_r.key_mult <= cfg_wdata[acs_pkg::KEY_W-1:0];
        end
        acs_pkg::CFG_KEY_ADD: begin
          cfg_r.key_add <= cfg_wdata[acs_pkg::KEY_W-1:0];
        end
        acs_pkg::CFG_ALPHA_SIZE: begin
          cfg_r.alpha_size <= cfg_wdata[acs_pkg::ASZ_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  acs_ctrl #(
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_symbol  (in_symbol_in),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_sym    (res_sym),
    .res_status (res_status)
  );

  // The output register frees the sequencer as soon as a result is handed
  // over, so the next request can start while this one waits.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_sym_r    <= res_sym;
        out_status_r <= res_status;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_symbol_out = out_sym_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for affine_cipher_symbol: directed table plus random
// phases under bursty sender and stalling receiver. Depends on acs_pkg and the RTL.
`default_nettype none

module tb_top;
  import acs_pkg::*;

  localparam int SYM_W = SYMBOL_BITS_DEF;
  localparam int MAX_ALPHABET = 1 << SYM_W;

  // Decrypt opcode and the one register index that maps to no register.
  localparam logic OP_DEC = ~OP_ENC;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam int RANDOM_PHASES = 13;
  localparam int REQS_PER_PHASE = 100;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 250;

  typedef struct packed {
    logic [SYM_W-1:0]    symbol;
    logic [STATUS_W-1:0] status;
  } cipher_result_t;

  // One row of the directed table. The register values are applied before the
  // request whenever they differ from what the block currently holds.
  typedef struct {
    logic [ASZ_W-1:0]    size_word;
    logic [KEY_W-1:0]    mult_key;
    logic [KEY_W-1:0]    shift_key;
    logic                op;
    logic [SYM_W-1:0]    sym;
    bit                  typed;
    logic [SYM_W-1:0]    exp_sym;
    logic [STATUS_W-1:0] exp_status;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = 1'b0;
  logic [SYM_W-1:0]      in_symbol_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SYM_W-1:0]      out_symbol_out;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copies that the predictor works from; they follow every write.
  logic [KEY_W-1:0] mult_key_reg = KEY_MULT_RST;
  logic [KEY_W-1:0] shift_key_reg = KEY_ADD_RST;
  logic [ASZ_W-1:0] size_reg = ALPHA_SIZE_RST;

  // Results still owed by the block, oldest first.
  cipher_result_t results_due[$];
  int mismatch_count = 0;

  dir_row_t dir_rows[23];

  affine_cipher_symbol u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_symbol_in   (in_symbol_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol_out (out_symbol_out),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The modulus actually in use: the alphabet size clamped to 2..2^SYMBOL_BITS.
  function automatic int unsigned alphabet_modulus();
    int unsigned m;
    m = size_reg;
    if (m < 2) m = 2;
    if (m > MAX_ALPHABET) m = MAX_ALPHABET;
    return m;
  endfunction

  // Extended Euclid. Returns 0 when the key shares a factor with the modulus,
  // a zero key included, since then the remainder chain ends on m itself.
  function automatic bit invert_mod(input int key, input int m, output int inv);
    int r0, r1, s0, s1, q, rt, st;
    r0 = m;
    r1 = key;
    s0 = 0;
    s1 = 1;
    inv = 0;
    while (r1 != 0) begin
      q  = r0 / r1;
      rt = r0 - q * r1;
      st = s0 - q * s1;
      r0 = r1;
      r1 = rt;
      s0 = s1;
      s1 = st;
    end
    if (r0 != 1) return 1'b0;
    s0 = s0 % m;
    if (s0 < 0) s0 += m;
    inv = s0;
    return 1'b1;
  endfunction

  function automatic cipher_result_t predict_cipher(input logic op, input logic [SYM_W-1:0] sym);
    int m, a, b, inv;
    cipher_result_t r;
    m = alphabet_modulus();
    // Keys at or above the alphabet size are reduced first.
    a = mult_key_reg % m;
    b = shift_key_reg % m;
    r = '0;
    r.status = ST_OK;
    if (sym >= m) begin
      // Range check wins over the key check, on both opcodes.
      r.status = ST_RANGE;
    end else if (op == OP_ENC) begin
      r.symbol = SYM_W'((a * sym + b) % m);
    end else if (!invert_mod(a, m, inv)) begin
      r.status = ST_NOINV;
    end else begin
      r.symbol = SYM_W'((inv * ((sym + m - b) % m)) % m);
    end
    return r;
  endfunction

  // Offers one request and holds it until the block takes it. The expectation
  // is queued at the accepting edge, well before the result can come back.
  task automatic send_request(input logic op, input logic [SYM_W-1:0] sym,
                              input bit typed, input cipher_result_t typed_result);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_symbol_in <= sym;
    do @(posedge clk); while (!in_ready);
    results_due.push_back(typed ? typed_result : predict_cipher(op, sym));
  endtask

  // Stops offering and waits until every result owed has been taken, then
  // lets the monitor's last pop settle before anything else moves.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_KEY_MULT:   mult_key_reg = data[KEY_W-1:0];
      CFG_KEY_ADD:    shift_key_reg = data[KEY_W-1:0];
      CFG_ALPHA_SIZE: size_reg = data[ASZ_W-1:0];
      default: ;
    endcase
  endtask

  // Drains the block, then rewrites all three registers back to back, and
  // optionally the spare index after them. The write enable is only lowered
  // after the last write, so it never gets two updates in one time step.
  task automatic set_keys(input logic [CFG_DATA_W-1:0] mult_word,
                          input logic [CFG_DATA_W-1:0] add_word,
                          input logic [CFG_DATA_W-1:0] size_word,
                          input bit with_spare);
    wait_idle();
    write_reg(CFG_KEY_MULT, mult_word);
    write_reg(CFG_KEY_ADD, add_word);
    write_reg(CFG_ALPHA_SIZE, size_word);
    if (with_spare) write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom_range(0, 511)));
    cfg_we <= 1'b0;
  endtask

  // Result monitor: every taken result is matched against the oldest request
  // still owed, field by field.
  always @(posedge clk) begin : check_results
    cipher_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: symbol_out %0d status %0d", out_symbol_out, out_status);
        mismatch_count++;
      end else begin
        due = results_due.pop_front();
        if (out_symbol_out !== due.symbol) begin
          $error("symbol_out: expected %0d, got %0d", due.symbol, out_symbol_out);
          mismatch_count++;
        end
        if (out_status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver. It switches between stall patterns of random length: always
  // ready, coin flip, one cycle in four, and mostly stalled. Once, after a few
  // hundred results, it holds off for a long stretch so that the output
  // register fills, the next request finishes behind it and in_ready drops
  // while the sender keeps offering.
  int rx_taken = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && rx_taken >= LONG_HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_cycle % 4) == 0;
          default: out_ready <= $urandom_range(0, 7) == 0;
        endcase
      end
      rx_cycle++;
    end
  end

  // Stimulus. The directed table comes first, then random phases, each with
  // its own register setting. Every phase boundary drains the block, so the
  // sender also pauses until nothing is owed.
  initial begin : stimulus
    cipher_result_t typed_result;
    int unsigned m;
    int inv_tmp;
    int burst_left;
    int gap;
    bit idle_on;
    logic [KEY_W-1:0] key;
    logic [CFG_DATA_W-1:0] mult_word, add_word, size_word;
    logic op;
    logic [SYM_W-1:0] sym;

    // Rows with an expected value typed in are the obvious ones: identity keys,
    // a zero key on encrypt, out-of-range symbols and keys with no inverse.
    dir_rows = '{
      '{9'd26,  8'd1,   8'd0,   OP_ENC, 8'd0,   1'b1, 8'd0,  ST_OK},
      '{9'd26,  8'd1,   8'd0,   OP_ENC, 8'd25,  1'b1, 8'd25, ST_OK},
      '{9'd26,  8'd1,   8'd0,   OP_DEC, 8'd25,  1'b1, 8'd25, ST_OK},
      '{9'd26,  8'd1,   8'd0,   OP_ENC, 8'd26,  1'b1, 8'd0,  ST_RANGE},
      '{9'd26,  8'd1,   8'd0,   OP_DEC, 8'd255, 1'b1, 8'd0,  ST_RANGE},
      // Key sharing a factor with the size: decrypt refuses, encrypt does not.
      '{9'd26,  8'd13,  8'd5,   OP_DEC, 8'd3,   1'b1, 8'd0,  ST_NOINV},
      '{9'd26,  8'd13,  8'd5,   OP_ENC, 8'd3,   1'b0, 8'd0,  ST_OK},
      '{9'd26,  8'd13,  8'd5,   OP_DEC, 8'd30,  1'b1, 8'd0,  ST_RANGE},
      // Zero key.
      '{9'd26,  8'd0,   8'd0,   OP_DEC, 8'd1,   1'b1, 8'd0,  ST_NOINV},
      '{9'd26,  8'd0,   8'd0,   OP_ENC, 8'd7,   1'b1, 8'd0,  ST_OK},
      // Keys at or above the size are reduced first.
      '{9'd26,  8'd26,  8'd30,  OP_DEC, 8'd4,   1'b1, 8'd0,  ST_NOINV},
      '{9'd26,  8'd27,  8'd30,  OP_ENC, 8'd4,   1'b0, 8'd0,  ST_OK},
      '{9'd26,  8'd27,  8'd30,  OP_DEC, 8'd4,   1'b0, 8'd0,  ST_OK},
      // Alphabet size below two acts as two.
      '{9'd0,   8'd1,   8'd0,   OP_ENC, 8'd1,   1'b1, 8'd1,  ST_OK},
      '{9'd0,   8'd1,   8'd0,   OP_ENC, 8'd2,   1'b1, 8'd0,  ST_RANGE},
      '{9'd1,   8'd1,   8'd1,   OP_DEC, 8'd1,   1'b0, 8'd0,  ST_OK},
      // Alphabet size above the symbol range clamps to 256, then exactly 256 and 200.
      '{9'd511, 8'd255, 8'd255, OP_ENC, 8'd255, 1'b0, 8'd0,  ST_OK},
      '{9'd511, 8'd255, 8'd255, OP_DEC, 8'd0,   1'b0, 8'd0,  ST_OK},
      '{9'd511, 8'd255, 8'd255, OP_DEC, 8'd255, 1'b0, 8'd0,  ST_OK},
      '{9'd256, 8'd2,   8'd0,   OP_DEC, 8'd0,   1'b1, 8'd0,  ST_NOINV},
      '{9'd256, 8'd2,   8'd0,   OP_ENC, 8'd128, 1'b0, 8'd0,  ST_OK},
      '{9'd200, 8'd3,   8'd199, OP_ENC, 8'd199, 1'b0, 8'd0,  ST_OK},
      '{9'd200, 8'd3,   8'd199, OP_DEC, 8'd0,   1'b0, 8'd0,  ST_OK}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].size_word != size_reg || dir_rows[i].mult_key != mult_key_reg ||
          dir_rows[i].shift_key != shift_key_reg) begin
        set_keys({1'b0, dir_rows[i].mult_key}, {1'b0, dir_rows[i].shift_key},
                 dir_rows[i].size_word, 1'b0);
      end
      typed_result.symbol = dir_rows[i].exp_sym;
      typed_result.status = dir_rows[i].exp_status;
      send_request(dir_rows[i].op, dir_rows[i].sym, dir_rows[i].typed, typed_result);
    end

    // Random phases. The first three pin the size to its extremes: exactly
    // 256, above 256 and below or at two. Keys are mostly invertible so that
    // decrypt does real work; the spare bit of the write data is random on
    // key writes and must be ignored.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: size_word = 9'd256;
        1: size_word = CFG_DATA_W'($urandom_range(257, 511));
        2: size_word = CFG_DATA_W'($urandom_range(0, 2));
        default: begin
          case ($urandom_range(0, 9))
            0: size_word = CFG_DATA_W'($urandom_range(0, 1));
            1: size_word = 9'd256;
            2: size_word = CFG_DATA_W'($urandom_range(257, 511));
            default: size_word = CFG_DATA_W'($urandom_range(2, 255));
          endcase
        end
      endcase
      m = size_word < 2 ? 2 : (size_word > MAX_ALPHABET ? MAX_ALPHABET : size_word);
      if ($urandom_range(0, 3) != 0) begin
        do key = KEY_W'($urandom_range(0, 255));
        while (!invert_mod(key % m, m, inv_tmp));
      end else begin
        key = KEY_W'($urandom_range(0, 255));
      end
      mult_word = CFG_DATA_W'(key) + ($urandom_range(0, 1) ? 9'd256 : 9'd0);
      add_word  = CFG_DATA_W'($urandom_range(0, 511));
      set_keys(mult_word, add_word, size_word, phase == 0);

      // Every fourth phase the sender never idles; the others come in bursts.
      idle_on = (phase % 4) != 3;
      burst_left = 0;
      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          gap = idle_on ? $urandom_range(1, 12) : 0;
          burst_left = $urandom_range(1, 16);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        op = 1'($urandom_range(0, 1));
        // Mostly symbols inside the alphabet, some anywhere in the field.
        if ($urandom_range(0, 9) == 0) sym = SYM_W'($urandom_range(0, 255));
        else sym = SYM_W'($urandom_range(0, m - 1));
        send_request(op, sym, 1'b0, '0);
        burst_left--;
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Several times the slowest legal run: every request a long decrypt behind
  // the worst receiver stalls and sender gaps, plus the long hold.
  initial begin : watchdog
    #16_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
